// ===== rtl/crmd_pkg.sv =====
// Package for the cheapest-ready-machine dispatcher: constants, words and running state.
`timescale 1ns / 1ps
`default_nettype none
package crmd_pkg;

    localparam int MACHINES = 8;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;
    localparam int TIME_W   = 32;
    localparam int COST_W   = 16;
    localparam int DUR_W    = 16;

    localparam logic [CNT_W-1:0]  COUNT_RESET   = 4'd8;
    localparam logic [CNT_W-1:0]  COUNT_MAX     = 4'd8;
    localparam logic [COST_W-1:0] UNUSABLE_COST = 16'hFFFF;
    localparam logic [TIME_W-1:0] TIME_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [TIME_W-1:0] job_start;
        logic [COST_W-1:0] machine_cost;
        logic [DUR_W-1:0]  step_duration;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        chosen_machine;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic              was_ready;
    } t_out_word;

    // Best candidates seen so far in the current job.
    typedef struct packed {
        logic              ready_found;
        logic [COST_W-1:0] best_cost;
        logic [IDX_W-1:0]  ready_machine;
        logic [DUR_W-1:0]  ready_duration;
        logic [TIME_W-1:0] ready_busy;
        logic [IDX_W-1:0]  free_machine;
        logic [TIME_W-1:0] free_time;
        logic [DUR_W-1:0]  free_duration;
    } t_run;

    localparam t_run RUN_CLEAR = '{
        ready_found:    1'b0,
        best_cost:      UNUSABLE_COST,
        ready_machine:  '0,
        ready_duration: '0,
        ready_busy:     '0,
        free_machine:   '0,
        free_time:      '0,
        free_duration:  '0
    };

endpackage
`default_nettype wire

// ===== rtl/crmd_entry_eval.sv =====
// Per-entry compare and select that folds one machine entry into the running candidates.
`timescale 1ns / 1ps
`default_nettype none
module crmd_entry_eval (
    input  wire crmd_pkg::t_run                  i_run,
    input  wire crmd_pkg::t_in_word              i_word,
    input  wire logic [crmd_pkg::IDX_W-1:0]      i_idx,
    input  wire logic [crmd_pkg::TIME_W-1:0]     i_busy,
    output crmd_pkg::t_run                       o_run
);

    always_comb begin
        o_run = i_run;
        // take the cheaper ready machine; strict compare keeps the lower index
        if ((i_busy <= i_word.job_start) && (i_word.machine_cost < i_run.best_cost)) begin
            o_run.best_cost      = i_word.machine_cost;
            o_run.ready_found    = 1'b1;
            o_run.ready_machine  = i_idx;
            o_run.ready_duration = i_word.step_duration;
            o_run.ready_busy     = i_busy;
        end
        // track the machine that frees first
        if ((i_idx == '0) || (i_busy < i_run.free_time)) begin
            o_run.free_time     = i_busy;
            o_run.free_machine  = i_idx;
            o_run.free_duration = i_word.step_duration;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/crmd_busy_table.sv =====
// Busy-until time per machine: one read port by entry index, one write port on dispatch.
`timescale 1ns / 1ps
`default_nettype none
module crmd_busy_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [crmd_pkg::IDX_W-1:0]      i_rd_idx,
    output logic      [crmd_pkg::TIME_W-1:0]     o_rd_busy,
    input  wire logic                            i_wr_en,
    input  wire logic [crmd_pkg::IDX_W-1:0]      i_wr_idx,
    input  wire logic [crmd_pkg::TIME_W-1:0]     i_wr_data
);

    logic [crmd_pkg::TIME_W-1:0] r_busy [crmd_pkg::MACHINES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < crmd_pkg::MACHINES; k++) begin
                r_busy[k] <= '0;
            end
        end else if (i_wr_en) begin
            r_busy[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_busy = r_busy[i_rd_idx];

endmodule
`default_nettype wire

// ===== rtl/cheapest_ready_machine_dispatch.sv =====
// Top level of the cheapest-ready-machine job dispatcher.
//
// Usage:
//   A job enters on the input channel as machine_count words, one per machine
//   in machine order, each with the job start, that machine's cost and its
//   duration (cost 65535 keeps the machine out of the ready pick). After the last word the
//   output channel carries one word: chosen machine, start, finish and whether
//   a ready machine was used (0 means the first-free fallback).
//   The config channel writes machine_count (0 acts as 1, above 8 acts as 8);
//   write it only while no job is in flight.
// Timing:
//   Each input word is captured in the input register and evaluated there
//   against the busy table; a last word's result is loaded into the output
//   register as that word leaves the input register, driving o_out_valid.
//   One word per cycle is sustained while no last word waits; the busy table
//   is written as a last word is evaluated, so the next job sees it at once.
// Reset:
//   Busy times clear to zero, machine_count returns to 8, any partial job drops.
// Stall:
//   The output register holds its word until taken. Non-last words keep
//   flowing; a last word waits in the input register until the output
//   register frees, and input ready drops only then.
`timescale 1ns / 1ps
`default_nettype none
module cheapest_ready_machine_dispatch (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire crmd_pkg::t_in_word           i_in_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output crmd_pkg::t_out_word               o_out_word,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [crmd_pkg::CNT_W-1:0]   i_cfg_data
);

    // configuration
    logic [crmd_pkg::CNT_W-1:0]  r_count;
    logic [crmd_pkg::CNT_W-1:0]  cnt_use;

    // input register
    logic                        r_in_valid;
    crmd_pkg::t_in_word          r_in_word;

    // job progress
    logic [crmd_pkg::IDX_W-1:0]  r_idx;
    crmd_pkg::t_run              r_run;
    crmd_pkg::t_run              n_run;
    logic [crmd_pkg::TIME_W-1:0] rd_busy;

    // output register
    logic                        r_out_valid;
    crmd_pkg::t_out_word         r_out_word;
    crmd_pkg::t_out_word         n_out_word;

    logic                        is_last;
    logic                        out_free;
    logic                        advance;
    logic                        dispatch;
    logic [crmd_pkg::TIME_W-1:0] pick_busy;
    logic [crmd_pkg::DUR_W-1:0]  pick_dur;
    logic [crmd_pkg::IDX_W-1:0]  pick_idx;
    logic [crmd_pkg::TIME_W-1:0] start_t;
    logic [crmd_pkg::TIME_W:0]   sum_t;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= crmd_pkg::COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // clamp the machine count into 1..MACHINES
    always_comb begin
        if (r_count == '0) begin
            cnt_use = crmd_pkg::CNT_W'(1);
        end else if (r_count > crmd_pkg::COUNT_MAX) begin
            cnt_use = crmd_pkg::COUNT_MAX;
        end else begin
            cnt_use = r_count;
        end
    end

    // a word at or past the last index in use ends the job
    assign is_last  = ((crmd_pkg::CNT_W'(r_idx) + crmd_pkg::CNT_W'(1)) >= cnt_use);
    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = r_in_valid && (!is_last || out_free);
    assign dispatch = advance && is_last;

    assign o_in_ready = !r_in_valid || advance;

    // input register: hold the word until it is evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    crmd_busy_table u_busy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_idx),
        .o_rd_busy (rd_busy),
        .i_wr_en   (dispatch),
        .i_wr_idx  (pick_idx),
        .i_wr_data (n_out_word.finish_time)
    );

    crmd_entry_eval u_eval (
        .i_run  (r_run),
        .i_word (r_in_word),
        .i_idx  (r_idx),
        .i_busy (rd_busy),
        .o_run  (n_run)
    );

    // pick the cheapest ready machine, else the first to free
    always_comb begin
        if (n_run.ready_found) begin
            pick_idx  = n_run.ready_machine;
            pick_busy = n_run.ready_busy;
            pick_dur  = n_run.ready_duration;
        end else begin
            pick_idx  = n_run.free_machine;
            pick_busy = n_run.free_time;
            pick_dur  = n_run.free_duration;
        end
        start_t = (pick_busy > r_in_word.job_start) ? pick_busy : r_in_word.job_start;
        sum_t   = {1'b0, start_t} + (crmd_pkg::TIME_W + 1)'(pick_dur);
        n_out_word.chosen_machine = 3'(pick_idx);
        n_out_word.start_time     = start_t;
        // saturate the finish on carry out
        n_out_word.finish_time    = sum_t[crmd_pkg::TIME_W] ? crmd_pkg::TIME_MAX
                                                            : sum_t[crmd_pkg::TIME_W-1:0];
        n_out_word.was_ready      = n_run.ready_found;
    end

    // job progress: advance the entry index, clear after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_run <= crmd_pkg::RUN_CLEAR;
        end else if (advance) begin
            if (is_last) begin
                r_idx <= '0;
                r_run <= crmd_pkg::RUN_CLEAR;
            end else begin
                r_idx <= r_idx + crmd_pkg::IDX_W'(1);
                r_run <= n_run;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= dispatch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dispatch) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    a_dispatch_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dispatch |=> o_out_valid)
        else $error("dispatched job did not reach the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !dispatch)
        else $error("result overwritten while stalled");

    a_finish_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.finish_time >= o_out_word.start_time))
        else $error("finish before start");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && is_last && r_out_valid))
        else $error("input stalled without a blocked last word");

endmodule
`default_nettype wire
